// File: design/mrs_pkg.sv
// shared constants, state encoding and crc unit control for the modbus rtu slave
`default_nettype none

package mrs_pkg;

  localparam int unsigned FrameLen  = 8;
  localparam int unsigned StoredLen = 6;

  localparam logic [15:0] CrcInit   = 16'hFFFF;
  localparam logic [15:0] CrcPoly   = 16'hA001;
  localparam logic [7:0]  FnRead    = 8'h03;
  localparam logic [7:0]  FnWrite   = 8'h06;
  localparam logic [7:0]  ReadCount = 8'h02;
  localparam logic [15:0] HoldReset = 16'd123;
  localparam logic [7:0]  AddrReset = 8'h01;

  // number of payload bytes ahead of the crc in each reply
  localparam logic [2:0] ReadDataLen  = 3'd5;
  localparam logic [2:0] WriteDataLen = 3'd6;
  localparam logic [2:0] LastPos      = 3'(FrameLen - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOAD = 3'b010,
    S_CRC  = 3'b100
  } state_e;

  typedef struct packed {
    logic       init;
    logic       load;
    logic [7:0] data;
  } crc_ctrl_t;

endpackage

`default_nettype wire

// File: design/mrs_if.sv
// valid/ready channels for received and transmitted items
`default_nettype none

interface mrs_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface mrs_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last_byte;

  modport source (output valid, output tx_byte, output last_byte, input ready);
  modport sink (input valid, input tx_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// File: design/modbus_rtu_single_register_slave.sv
// modbus rtu single holding register slave with serial crc reply generation
//
// rx carries one received byte per item; every eight items form one request
// frame, counted from reset. the request crc is not checked. when the eighth
// byte of a frame arrives and byte 0 matches the slave address, function 3
// answers with 7 items and function 6 writes the register (at address 0) and
// answers with 8 items; any other frame gives nothing. last_byte marks the
// final item of a reply. the address register is written by cfg_we_i and
// cfg_wdata_i; the user must write it only while the block is idle, as the
// block itself does not enforce this. rx is not ready while a reply is built.
// for each reply payload byte the sequencer loads the byte into the output
// register and the shared crc unit, waits while the crc unit shifts once per
// data bit and then returns to the load step; each crc byte goes out from
// the load step with no crc run. the eighth byte of an answered frame moves
// the sequencer into the load step.
// reset: frame position 0, address 1, holding register 123, no item pending.
// a stalled receiver holds the output register; the sequencer waits for the
// slot to free before loading the next byte, so nothing is lost or repeated.
`default_nettype none

module modbus_rtu_single_register_slave
  import mrs_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i,
  mrs_rx_if.sink          rx,
  mrs_tx_if.source        tx
);

  state_e      state_q, state_d;
  logic [7:0]  slave_addr_q;
  logic [2:0]  pos_q;
  logic [7:0]  req_q [StoredLen];
  logic [15:0] holding_q;
  logic [15:0] value_q, value_d;
  logic        is_write_q, is_write_d;
  logic [2:0]  idx_q, idx_d;

  // output register
  logic        tx_valid_q, tx_valid_d;
  logic [7:0]  tx_byte_q, tx_byte_d;
  logic        tx_last_q, tx_last_d;

  crc_ctrl_t   crc_ctrl;
  logic        crc_busy;
  logic [15:0] crc_val;

  logic        rx_fire;
  logic        frame_end;
  logic        addr_hit;
  logic [15:0] reg_addr;
  logic        slot_free;
  logic [2:0]  data_len;
  logic [7:0]  cur_byte;

  mrs_crc u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (crc_ctrl),
    .busy_o (crc_busy),
    .crc_o  (crc_val)
  );

  assign rx.ready  = (state_q == S_IDLE);
  assign rx_fire   = rx.valid && rx.ready;
  assign frame_end = rx_fire && (pos_q == LastPos);
  assign addr_hit  = (req_q[0] == slave_addr_q);
  assign reg_addr  = {req_q[2], req_q[3]};
  assign slot_free = !tx_valid_q || tx.ready;
  assign data_len  = is_write_q ? WriteDataLen : ReadDataLen;

  // reply payload byte at the current position
  always_comb begin
    case (idx_q)
      3'd0:    cur_byte = req_q[0];
      3'd1:    cur_byte = is_write_q ? req_q[1] : FnRead;
      3'd2:    cur_byte = is_write_q ? req_q[2] : ReadCount;
      3'd3:    cur_byte = is_write_q ? req_q[3] : value_q[15:8];
      3'd4:    cur_byte = is_write_q ? req_q[4] : value_q[7:0];
      default: cur_byte = req_q[5];
    endcase
  end

  // reply sequencer
  always_comb begin
    state_d       = state_q;
    value_d       = value_q;
    is_write_d    = is_write_q;
    idx_d         = idx_q;
    tx_valid_d    = tx_valid_q && !tx.ready;
    tx_byte_d     = tx_byte_q;
    tx_last_d     = tx_last_q;
    crc_ctrl.init = 1'b0;
    crc_ctrl.load = 1'b0;
    crc_ctrl.data = cur_byte;

    unique case (state_q)
      S_IDLE: begin
        if (frame_end && addr_hit && (req_q[1] == FnRead || req_q[1] == FnWrite)) begin
          is_write_d = (req_q[1] == FnWrite);
          value_d    = (reg_addr == 16'd0) ? holding_q : 16'd0;
          idx_d      = '0;
          state_d    = S_LOAD;
        end
      end
      S_LOAD: begin
        if (slot_free) begin
          tx_valid_d = 1'b1;
          tx_last_d  = 1'b0;
          idx_d      = idx_q + 3'd1;
          if (idx_q < data_len) begin
            tx_byte_d     = cur_byte;
            crc_ctrl.load = 1'b1;
            crc_ctrl.init = (idx_q == 3'd0);
            state_d       = S_CRC;
          end else if (idx_q == data_len) begin
            // crc goes out low byte first
            tx_byte_d = crc_val[7:0];
          end else begin
            tx_byte_d = crc_val[15:8];
            tx_last_d = 1'b1;
            state_d   = S_IDLE;
          end
        end
      end
      S_CRC: begin
        if (!crc_busy) begin
          state_d = S_LOAD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      slave_addr_q <= AddrReset;
      pos_q        <= '0;
      holding_q    <= HoldReset;
      tx_valid_q   <= 1'b0;
      idx_q        <= '0;
      is_write_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      tx_valid_q <= tx_valid_d;
      idx_q      <= idx_d;
      is_write_q <= is_write_d;
      if (cfg_we_i) begin
        slave_addr_q <= cfg_wdata_i;
      end
      if (rx_fire) begin
        pos_q <= pos_q + 3'd1;
      end
      // write request to register 0 updates the holding register
      if (frame_end && addr_hit && req_q[1] == FnWrite && reg_addr == 16'd0) begin
        holding_q <= {req_q[4], req_q[5]};
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    value_q   <= value_d;
    tx_byte_q <= tx_byte_d;
    tx_last_q <= tx_last_d;
    if (rx_fire && pos_q < 3'(StoredLen)) begin
      req_q[pos_q] <= rx.rx_byte;
    end
  end

  assign tx.valid     = tx_valid_q;
  assign tx.tx_byte   = tx_byte_q;
  assign tx.last_byte = tx_last_q;

  // holding register only moves on the final byte of a frame
  a_hold_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(holding_q) |-> $past(rx_fire) && $past(pos_q) == LastPos)
    else $error("holding register changed outside a frame end");

  // a crc load always starts a shift run tracked by the sequencer
  a_crc_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    crc_ctrl.load |=> state_q == S_CRC && crc_busy)
    else $error("crc load did not start a shift run");

  // bytes are only loaded once the crc unit has settled
  a_load_idle_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LOAD |-> !crc_busy)
    else $error("reply byte loaded while crc unit busy");

endmodule

`default_nettype wire

// File: design/mrs_crc.sv
// bit-serial modbus crc-16 unit, one shift per cycle
`default_nettype none

module mrs_crc
  import mrs_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire crc_ctrl_t   ctrl_i,
  output logic             busy_o,
  output logic [15:0]      crc_o
);

  logic [15:0] crc_q, crc_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [15:0] base;

  always_comb begin
    base   = ctrl_i.init ? CrcInit : crc_q;
    crc_d  = crc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (ctrl_i.load) begin
      crc_d  = base ^ {8'h00, ctrl_i.data};
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      crc_d = crc_q[0] ? ((crc_q >> 1) ^ CrcPoly) : (crc_q >> 1);
      cnt_d = cnt_q + 3'd1;
      if (cnt_q == 3'd7) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= CrcInit;
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      crc_q  <= crc_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  assign busy_o = busy_q;
  assign crc_o  = crc_q;

endmodule

`default_nettype wire

// File: tb/testbench.sv
// self-checking testbench for the modbus rtu single register slave with a reply scoreboard
`timescale 1ns / 1ps

module testbench;
  import mrs_pkg::*;

  // one expected reply item: the byte and its end-of-frame flag
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } reply_item_t;

  typedef logic [7:0] frame_t [FrameLen];

  // request shapes the stimulus draws from
  typedef enum logic [2:0] {
    FR_READ_ZERO,
    FR_READ_OTHER,
    FR_WRITE_ZERO,
    FR_WRITE_OTHER,
    FR_UNKNOWN_FN,
    FR_OTHER_ADDR,
    FR_RANDOM
  } frame_kind_e;

  localparam int unsigned CycleLimit  = 200000;
  // idle time added after every queued reply item is back
  localparam int unsigned SettleCycles = 80;
  localparam int unsigned NumPhases    = 7;
  localparam int unsigned FramesPerPhase = 5;

  // scoreboard: tracks the slave's frame state and queues the reply items it must send
  class reply_scoreboard;
    logic [7:0]  slave_addr;
    logic [2:0]  frame_pos;
    logic [7:0]  frame_bytes [StoredLen];
    logic [15:0] holding_reg;
    reply_item_t expected_q [$];
    int          mismatches;

    function new();
      slave_addr  = AddrReset;
      frame_pos   = '0;
      holding_reg = HoldReset;
      mismatches  = 0;
      foreach (frame_bytes[i]) frame_bytes[i] = '0;
    endfunction

    function logic [15:0] frame_crc(logic [7:0] msg [$]);
      logic [15:0] crc;
      crc = CrcInit;
      foreach (msg[i]) begin
        crc = crc ^ {8'h00, msg[i]};
        for (int b = 0; b < 8; b++) begin
          if (crc[0]) crc = (crc >> 1) ^ CrcPoly;
          else crc = crc >> 1;
        end
      end
      return crc;
    endfunction

    // one accepted request byte; the eighth byte of a frame may queue a reply
    function void note_request_byte(logic [7:0] b);
      logic [15:0] reg_num;
      logic [15:0] value;
      logic [15:0] crc;
      logic [7:0]  reply [$];
      if (frame_pos < StoredLen) frame_bytes[frame_pos] = b;
      if (frame_pos != LastPos) begin
        frame_pos = frame_pos + 3'd1;
        return;
      end
      frame_pos = '0;
      if (frame_bytes[0] != slave_addr) return;
      reg_num = {frame_bytes[2], frame_bytes[3]};
      if (frame_bytes[1] == FnRead) begin
        value = (reg_num == 16'h0000) ? holding_reg : 16'h0000;
        reply = '{frame_bytes[0], FnRead, ReadCount, value[15:8], value[7:0]};
      end else if (frame_bytes[1] == FnWrite) begin
        if (reg_num == 16'h0000) holding_reg = {frame_bytes[4], frame_bytes[5]};
        for (int i = 0; i < StoredLen; i++) reply.push_back(frame_bytes[i]);
      end else begin
        return;
      end
      crc = frame_crc(reply);
      reply.push_back(crc[7:0]);
      reply.push_back(crc[15:8]);
      foreach (reply[i]) expected_q.push_back('{data: reply[i], last: (i == reply.size() - 1)});
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatches++;
    endtask

    task check_reply(logic [7:0] data, logic last);
      reply_item_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected tx item %02h last %b", data, last));
        return;
      end
      want = expected_q.pop_front();
      if (data !== want.data)
        report($sformatf("tx_byte %02h, expected %02h", data, want.data));
      if (last !== want.last)
        report($sformatf("last_byte %b, expected %b (byte %02h)", last, want.last, want.data));
    endtask
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [7:0] cfg_wdata_i;
  int         cycle_count = 0;
  int         burst_left = 0;

  mrs_rx_if rx_if ();
  mrs_tx_if tx_if ();

  reply_scoreboard sb = new();

  modbus_rtu_single_register_slave dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rx          (rx_if),
    .tx          (tx_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // both channels are sampled at the edge, before any driver update lands
  always @(posedge clk_i) begin
    if (rst_ni && rx_if.valid && rx_if.ready) sb.note_request_byte(rx_if.rx_byte);
    if (rst_ni && tx_if.valid && tx_if.ready) sb.check_reply(tx_if.tx_byte, tx_if.last_byte);
  end

  // receiver stalls follow an 8-bit mask, renewed when mask_age wraps; at
  // least a quarter of masks are all ones, so some stretches never stall
  logic [7:0] stall_mask = 8'hFF;
  logic [2:0] mask_idx = '0;
  logic [5:0] mask_age = '0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      tx_if.ready <= 1'b0;
    end else begin
      mask_idx <= mask_idx + 3'd1;
      mask_age <= mask_age + 6'd1;
      if (mask_age == '1)
        stall_mask <= ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
      tx_if.ready <= stall_mask[mask_idx];
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // one request item; the sender runs in bursts with random gaps in between
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        rx_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk_i); while (!rx_if.ready);
  endtask

  task automatic send_frame(input frame_t f);
    for (int i = 0; i < FrameLen; i++) send_byte(f[i]);
  endtask

  // hold off until every queued reply item is back, then let a dropped frame settle
  task automatic wait_drained();
    rx_if.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (sb.expected_q.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // only called while the slave is idle
  task automatic write_address(input logic [7:0] addr);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= addr;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.slave_addr = addr;
  endtask

  function automatic logic [15:0] other_register();
    case ($urandom_range(0, 3))
      0: return 16'h0001;
      1: return 16'h8000;
      2: return 16'hFFFF;
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  function automatic logic [15:0] random_word();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // builds one request; the trailing crc and the quantity field are arbitrary
  function automatic frame_t make_frame(input frame_kind_e kind, input logic [7:0] addr);
    frame_t      f;
    logic [15:0] reg_num;
    logic [15:0] word;
    logic [7:0]  fn;
    foreach (f[i]) f[i] = 8'($urandom);
    reg_num = 16'h0000;
    word    = random_word();
    fn      = FnRead;
    case (kind)
      FR_READ_ZERO:   fn = FnRead;
      FR_READ_OTHER:  begin fn = FnRead; reg_num = other_register(); end
      FR_WRITE_ZERO:  fn = FnWrite;
      FR_WRITE_OTHER: begin fn = FnWrite; reg_num = other_register(); end
      FR_UNKNOWN_FN:  do fn = 8'($urandom); while (fn == FnRead || fn == FnWrite);
      FR_OTHER_ADDR: begin
        addr = addr ^ 8'($urandom_range(1, 255));
        fn   = $urandom_range(0, 1) ? FnRead : FnWrite;
      end
      default: begin
        // fully random frame, addressed to us half the time
        if ($urandom_range(0, 1)) f[0] = addr;
        return f;
      end
    endcase
    f[0] = addr;
    f[1] = fn;
    {f[2], f[3]} = reg_num;
    {f[4], f[5]} = word;
    return f;
  endfunction

  function automatic frame_kind_e pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return FR_READ_ZERO;
    if (r < 40) return FR_READ_OTHER;
    if (r < 65) return FR_WRITE_ZERO;
    if (r < 75) return FR_WRITE_OTHER;
    if (r < 83) return FR_UNKNOWN_FN;
    if (r < 92) return FR_OTHER_ADDR;
    return FR_RANDOM;
  endfunction

  // the address changes between byte 3 and byte 4 of a frame; the frame is
  // judged against the new address, so it is built for either the new or the old one
  task automatic send_split_frame(input logic [7:0] new_addr);
    frame_t     f;
    logic [7:0] old_addr;
    old_addr = sb.slave_addr;
    f = make_frame($urandom_range(0, 1) ? FR_READ_ZERO : FR_WRITE_ZERO,
                   $urandom_range(0, 2) ? new_addr : old_addr);
    for (int i = 0; i < 4; i++) send_byte(f[i]);
    wait_drained();
    write_address(new_addr);
    for (int i = 4; i < FrameLen; i++) send_byte(f[i]);
  endtask

  initial begin
    logic [7:0] phase_addr;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= 8'h00;
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= 8'h00;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: read the reset value, write all ones to register 0,
    // then read the top register with a full quantity field (reads as zero)
    send_frame('{AddrReset, FnRead, 8'h00, 8'h00, 8'h00, 8'h01, 8'h84, 8'h0A});
    send_frame('{AddrReset, FnWrite, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF});
    send_frame('{AddrReset, FnRead, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00});

    // random phases, each under its own slave address; the first two use the extremes
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: phase_addr = 8'h00;
        1: phase_addr = 8'hFF;
        2: phase_addr = AddrReset;
        default: phase_addr = 8'($urandom);
      endcase
      wait_drained();
      write_address(phase_addr);
      for (int k = 0; k < FramesPerPhase; k++) begin
        send_frame(make_frame(pick_kind(), sb.slave_addr));
        // occasional full stop of the sender
        if ($urandom_range(0, 9) == 0) wait_drained();
      end
      if (p > 0) send_split_frame(8'($urandom));
    end

    wait_drained();
    if (sb.expected_q.size() != 0)
      sb.report($sformatf("%0d reply items never arrived", sb.expected_q.size()));
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/mrs_pkg.sv
design/mrs_if.sv
design/mrs_crc.sv
design/modbus_rtu_single_register_slave.sv
tb/testbench.sv
